>>> rtl/name_frequency_table_sorted_unit_assert.svh
// Assertion macros shared by the name frequency table RTL.
`ifndef NAME_FREQUENCY_TABLE_SORTED_UNIT_ASSERT_SVH
`define NAME_FREQUENCY_TABLE_SORTED_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define NFTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("nfts: same-cycle check failed");
`define NFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("nfts: next-cycle check failed");
`else
`define NFTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define NFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/nfts_pkg.sv
// Shared types, constants and the name normalizer of the name frequency table.
package nfts_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int NAME_BYTES    = 19;
	localparam int NAME_W        = 152;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int DISTINCT_W    = 6;
	localparam int OCC_W         = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	typedef enum logic [2:0] {
		STATUS_NEW          = 3'd0,
		STATUS_EXISTING     = 3'd1,
		STATUS_FULL         = 3'd2,
		STATUS_REPORT       = 3'd3,
		STATUS_REPORT_EMPTY = 3'd4
	} status_t;

	typedef struct packed {
		logic [23:0] hi;
		logic [63:0] mid;
		logic [63:0] lo;
	} name_t;

	// a name ends at its first zero byte; everything after reads as zero
	function automatic name_t normalize(input logic [63:0] lo, input logic [63:0] mid,
			input logic [23:0] hi);
		logic [NAME_W-1:0] flat;
		logic              ended;
		name_t             r;
		flat  = {hi, mid, lo};
		ended = 1'b0;
		for (int i = 0; i < NAME_W / 8; i++) begin
			if (i >= NAME_BYTES || flat[i*8 +: 8] == 8'h00) begin
				ended = 1'b1;
			end
			if (ended) begin
				flat[i*8 +: 8] = 8'h00;
			end
		end
		r = flat;
		return r;
	endfunction

endpackage

>>> rtl/nfts_req_if.sv
// Request channel: command and name words into the table.
interface nfts_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [63:0] name_bytes_lo;
	logic [63:0] name_bytes_mid;
	logic [23:0] name_bytes_hi;

	modport source (output valid, command, name_bytes_lo, name_bytes_mid, name_bytes_hi,
		input ready);
	modport sink (input valid, command, name_bytes_lo, name_bytes_mid, name_bytes_hi,
		output ready);
endinterface

>>> rtl/nfts_rsp_if.sv
// Result channel: status, entry name, count and distinct total out of the table.
interface nfts_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] entry_name_lo;
	logic [63:0] entry_name_mid;
	logic [23:0] entry_name_hi;
	logic [15:0] occurrences;
	logic [5:0]  distinct_total;
	logic        last;

	modport source (output valid, status, entry_name_lo, entry_name_mid, entry_name_hi,
		occurrences, distinct_total, last, input ready);
	modport sink (input valid, status, entry_name_lo, entry_name_mid, entry_name_hi,
		occurrences, distinct_total, last, output ready);
endinterface

>>> rtl/name_frequency_table_sorted_unit.sv
// Name frequency table with count-sorted report, one shared compare unit under a sequencer.
//
//  channel   dir  word                                      handshake
//  request   in   command, name_bytes_lo/mid/hi             valid/ready
//  result    out  status, entry_name_lo/mid/hi, occurrences, valid/ready
//                 distinct_total, last
//
// An insert makes one key compare per cycle over the stored names. A report makes one
// selection scan over the count memory per emitted entry, then a key read.
// Reset clears the sequencer, the fill count, the output valid and the scan and sort flags;
// the key and count memories are never cleared, entries at or above the fill count are never used.
// The request side is ready only in IDLE. A stalled result holds the sequencer before
// the next word is loaded; the final word of an item may wait while a new word is taken.
`include "name_frequency_table_sorted_unit_assert.svh"

module name_frequency_table_sorted_unit (
	input logic       clk,
	input logic       arst_n,
	nfts_req_if.sink  request,
	nfts_rsp_if.source result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_INS_HIT,
		ST_INS_MISS,
		ST_RPT_SCAN,
		ST_RPT_PICK,
		ST_RPT_EMIT,
		ST_RPT_EMPTY
	} state_t;

	state_t state_q;

	// fill count and the normalized name of the current insert
	logic [nfts_pkg::CNT_W-1:0]  used_q;
	nfts_pkg::name_t             name_q;

	// scan pointers: issue runs one ahead of the compare because of the read latency
	logic [nfts_pkg::CNT_W-1:0]  issue_q;
	logic                        chk_vld_q;
	logic [nfts_pkg::IDX_W-1:0]  chk_idx_q;
	logic [nfts_pkg::IDX_W-1:0]  hit_idx_q;
	logic [nfts_pkg::OCC_W-1:0]  cnt_hit_q;

	// selection sort: bound is the last emitted (count, index) key
	logic                        bound_inf_q;
	logic [nfts_pkg::OCC_W-1:0]  bound_cnt_q;
	logic [nfts_pkg::IDX_W-1:0]  bound_idx_q;
	logic                        best_vld_q;
	logic [nfts_pkg::OCC_W-1:0]  best_cnt_q;
	logic [nfts_pkg::IDX_W-1:0]  best_idx_q;
	logic [nfts_pkg::CNT_W-1:0]  rank_q;

	// output register
	logic                           res_vld_q;
	nfts_pkg::status_t              res_status_q;
	nfts_pkg::name_t                res_name_q;
	logic [nfts_pkg::OCC_W-1:0]     res_occ_q;
	logic [nfts_pkg::DISTINCT_W-1:0] res_total_q;
	logic                           res_last_q;

	// memories
	nfts_pkg::name_t             key_mem [nfts_pkg::TABLE_ENTRIES];
	logic [nfts_pkg::OCC_W-1:0]  cnt_mem [nfts_pkg::TABLE_ENTRIES];
	nfts_pkg::name_t             key_rd_q;
	logic [nfts_pkg::OCC_W-1:0]  cnt_rd_q;

	logic                        req_acc;
	logic                        slot_free;
	logic                        res_load;
	nfts_pkg::name_t             req_name;
	logic [nfts_pkg::CNT_W-1:0]  used_m1;
	logic                        chk_is_last;
	logic                        table_full;
	logic                        rd_en;
	logic [nfts_pkg::IDX_W-1:0]  rd_addr;
	logic                        key_we;
	logic                        cnt_we;
	logic [nfts_pkg::IDX_W-1:0]  cnt_wa;
	logic [nfts_pkg::OCC_W-1:0]  cnt_wd;
	logic                        below_bound;
	logic                        beats_best;

	assign request.ready = (state_q == ST_IDLE);
	assign req_acc       = request.valid && request.ready;
	assign slot_free     = !res_vld_q || result.ready;
	// a result word is loaded in any of the emitting states once the slot is free
	assign res_load      = slot_free && ((state_q == ST_INS_HIT) || (state_q == ST_INS_MISS) ||
		(state_q == ST_RPT_EMIT) || (state_q == ST_RPT_EMPTY));
	assign req_name      = nfts_pkg::normalize(request.name_bytes_lo, request.name_bytes_mid,
		request.name_bytes_hi);
	assign used_m1       = used_q - nfts_pkg::CNT_W'(1);
	assign chk_is_last   = ({1'b0, chk_idx_q} == used_m1);
	assign table_full    = (used_q == nfts_pkg::CNT_W'(nfts_pkg::TABLE_ENTRIES));

	// shared compare unit: candidate key below the bound, and at or above the best so far.
	// Later indexes win ties, so newer names come first among equal counts.
	assign below_bound = bound_inf_q || (cnt_rd_q < bound_cnt_q) ||
		(cnt_rd_q == bound_cnt_q && chk_idx_q < bound_idx_q);
	assign beats_best  = !best_vld_q || (cnt_rd_q >= best_cnt_q);

	// memory port control
	assign rd_en   = (state_q == ST_SEARCH) || (state_q == ST_RPT_SCAN) ||
		(state_q == ST_RPT_PICK);
	assign rd_addr = (state_q == ST_RPT_PICK) ? best_idx_q : issue_q[nfts_pkg::IDX_W-1:0];
	assign key_we  = (state_q == ST_INS_MISS) && slot_free && !table_full;
	assign cnt_we  = key_we || ((state_q == ST_INS_HIT) && slot_free);
	assign cnt_wa  = (state_q == ST_INS_HIT) ? hit_idx_q : used_q[nfts_pkg::IDX_W-1:0];
	assign cnt_wd  = (state_q == ST_INS_HIT) ? cnt_hit_q : nfts_pkg::OCC_W'(1);

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[used_q[nfts_pkg::IDX_W-1:0]] <= name_q;
		end
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (rd_en) begin
			key_rd_q <= key_mem[rd_addr];
			cnt_rd_q <= cnt_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			res_vld_q   <= 1'b0;
			chk_vld_q   <= 1'b0;
			best_vld_q  <= 1'b0;
			bound_inf_q <= 1'b1;
		end else begin
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						name_q      <= req_name;
						issue_q     <= '0;
						chk_vld_q   <= 1'b0;
						best_vld_q  <= 1'b0;
						bound_inf_q <= 1'b1;
						rank_q      <= '0;
						if (request.command == nfts_pkg::CMD_REPORT) begin
							state_q <= (used_q == '0) ? ST_RPT_EMPTY : ST_RPT_SCAN;
						end else begin
							state_q <= (used_q == '0) ? ST_INS_MISS : ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (chk_vld_q && key_rd_q == name_q) begin
						hit_idx_q <= chk_idx_q;
						cnt_hit_q <= (&cnt_rd_q) ? cnt_rd_q : cnt_rd_q + nfts_pkg::OCC_W'(1);
						chk_vld_q <= 1'b0;
						state_q   <= ST_INS_HIT;
					end else if (chk_vld_q && chk_is_last) begin
						chk_vld_q <= 1'b0;
						state_q   <= ST_INS_MISS;
					end else if (issue_q < used_q) begin
						chk_vld_q <= 1'b1;
						chk_idx_q <= issue_q[nfts_pkg::IDX_W-1:0];
						issue_q   <= issue_q + nfts_pkg::CNT_W'(1);
					end else begin
						chk_vld_q <= 1'b0;
					end
				end
				ST_INS_HIT: begin
					if (slot_free) begin
						res_status_q <= nfts_pkg::STATUS_EXISTING;
						res_name_q   <= name_q;
						res_occ_q    <= cnt_hit_q;
						res_total_q  <= nfts_pkg::DISTINCT_W'(used_q);
						res_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_INS_MISS: begin
					if (slot_free) begin
						res_name_q <= name_q;
						res_last_q <= 1'b1;
						if (table_full) begin
							res_status_q <= nfts_pkg::STATUS_FULL;
							res_occ_q    <= '0;
							res_total_q  <= nfts_pkg::DISTINCT_W'(used_q);
						end else begin
							res_status_q <= nfts_pkg::STATUS_NEW;
							res_occ_q    <= nfts_pkg::OCC_W'(1);
							res_total_q  <= nfts_pkg::DISTINCT_W'(used_q + nfts_pkg::CNT_W'(1));
							used_q       <= used_q + nfts_pkg::CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_RPT_SCAN: begin
					if (chk_vld_q && below_bound && beats_best) begin
						best_vld_q <= 1'b1;
						best_cnt_q <= cnt_rd_q;
						best_idx_q <= chk_idx_q;
					end
					if (chk_vld_q && chk_is_last) begin
						chk_vld_q <= 1'b0;
						state_q   <= ST_RPT_PICK;
					end else if (issue_q < used_q) begin
						chk_vld_q <= 1'b1;
						chk_idx_q <= issue_q[nfts_pkg::IDX_W-1:0];
						issue_q   <= issue_q + nfts_pkg::CNT_W'(1);
					end else begin
						chk_vld_q <= 1'b0;
					end
				end
				ST_RPT_PICK: begin
					state_q <= ST_RPT_EMIT;
				end
				ST_RPT_EMIT: begin
					if (slot_free) begin
						res_status_q <= nfts_pkg::STATUS_REPORT;
						res_name_q   <= key_rd_q;
						res_occ_q    <= cnt_rd_q;
						res_total_q  <= nfts_pkg::DISTINCT_W'(used_q);
						res_last_q   <= (rank_q == used_m1);
						bound_inf_q  <= 1'b0;
						bound_cnt_q  <= best_cnt_q;
						bound_idx_q  <= best_idx_q;
						best_vld_q   <= 1'b0;
						rank_q       <= rank_q + nfts_pkg::CNT_W'(1);
						issue_q      <= '0;
						chk_vld_q    <= 1'b0;
						state_q      <= (rank_q == used_m1) ? ST_IDLE : ST_RPT_SCAN;
					end
				end
				ST_RPT_EMPTY: begin
					if (slot_free) begin
						res_status_q <= nfts_pkg::STATUS_REPORT_EMPTY;
						res_name_q   <= '0;
						res_occ_q    <= '0;
						res_total_q  <= '0;
						res_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid          = res_vld_q;
	assign result.status         = res_status_q;
	assign result.entry_name_lo  = res_name_q.lo;
	assign result.entry_name_mid = res_name_q.mid;
	assign result.entry_name_hi  = res_name_q.hi;
	assign result.occurrences    = res_occ_q;
	assign result.distinct_total = res_total_q;
	assign result.last           = res_last_q;

	// fill count moves only when a new name is written
	`NFTS_ASSERT_NEXT(a_used_only_on_miss, clk, arst_n, state_q != ST_INS_MISS,
		used_q == $past(used_q))
	// report words come out in non-increasing count order
	`NFTS_ASSERT_IMPLY(a_report_order, clk, arst_n,
		(state_q == ST_RPT_EMIT) && slot_free && !bound_inf_q, cnt_rd_q <= bound_cnt_q)
	// a counted hit never carries a zero count
	`NFTS_ASSERT_IMPLY(a_hit_nonzero, clk, arst_n, state_q == ST_INS_HIT, cnt_hit_q != '0)

endmodule
